// ===== design/wpc_pkg.sv =====
package wpc_pkg;

    // Stream widths; the tdata widths are padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;

    // Fixed palette indices painted by every window
    localparam logic [7:0] TITLE_COLOR  = 8'h1F;
    localparam logic [7:0] BORDER_COLOR = 8'h0F;

    // Item kind carried on s_tuser
    typedef enum logic [0:0] {
        CMD_CREATE = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    // One input word, unpacked
    typedef struct packed {
        cmd_t               cmd;
        logic signed [10:0] left;
        logic signed [10:0] top;
        logic        [9:0]  width;
        logic        [9:0]  height;
        logic        [7:0]  color;
        logic        [8:0]  px;
        logic        [7:0]  py;
    } item_t;

    // Stored window geometry and body colour
    typedef struct packed {
        logic signed [10:0] left;
        logic signed [10:0] top;
        logic        [9:0]  width;
        logic        [9:0]  height;
        logic        [7:0]  color;
    } slot_t;

    // Per-slot offsets of the queried pixel, with a snapshot of the slot
    typedef struct packed {
        logic               vis;
        logic signed [11:0] dx;
        logic signed [11:0] dy;
        logic        [9:0]  width;
        logic        [9:0]  height;
        logic        [7:0]  color;
    } geo_t;

    // Per-slot paint decision
    typedef struct packed {
        logic       paint;
        logic [7:0] color;
    } hit_t;

    // Result word, create_ok in the lowest bit
    typedef struct packed {
        logic       pixel_covered;
        logic [7:0] pixel_color;
        logic [2:0] slot_index;
        logic       create_ok;
    } res_t;

endpackage

// ===== design/window_pixel_compositor_core.sv =====
// Window pixel compositor.
//
// The slave channel (s_tvalid, s_tready, s_tdata, s_tuser) takes one word per
// item: s_tuser selects a window create or a pixel query. A create takes the
// lowest free slot of the window table and reports it; a query returns the
// colour of one screen pixel with all windows painted in slot order, higher
// slots on top, each window as body, then title bar, then border.
// The master channel (m_tvalid, m_tready, m_tdata) gives exactly one result
// word per item, in order.
//
// The result reaches m_tdata through four registers: input register, offset
// stage (table read and update), compare stage, select and output register.
// A word can enter on every clock while m_tready is not held low, so
// throughput is one item per cycle; creates and queries may be freely
// interleaved, since the table is read and written in the offset stage only.
//
// Reset clears every slot to free and empties the pipeline. When the receiver
// holds m_tready low, each stage keeps its word; bubbles close up and then
// s_tready falls, with nothing lost or repeated.
module window_pixel_compositor_core #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int WINDOW_SLOTS  = 8,
    parameter int TITLE_ROWS    = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // win_left[10:0], win_top[21:11], win_width[31:22], win_height[41:32],
    // win_color[49:42], pixel_x[58:50], pixel_y[66:59], zero[71:67]
    input  logic [wpc_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[0]
    input  logic [wpc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // create_ok[0], slot_index[3:1], pixel_color[11:4], pixel_covered[12],
    // zero[15:13]
    output logic [wpc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import wpc_pkg::*;

    localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam logic        [9:0]  SCR_W     = 10'(SCREEN_WIDTH);
    localparam logic        [9:0]  SCR_H     = 10'(SCREEN_HEIGHT);
    localparam logic signed [11:0] TITLE_LIM = 12'(TITLE_ROWS);

    // Window table
    logic [WINDOW_SLOTS-1:0] vis_reg;
    slot_t                   slot_reg [WINDOW_SLOTS];

    // Pipeline registers
    logic  p1_valid_reg;
    item_t p1_item_reg;

    logic              p2_valid_reg;
    logic              p2_ok_reg;
    logic [SLOT_W-1:0] p2_idx_reg;
    logic              p2_hit_en_reg;
    geo_t              p2_geo_reg [WINDOW_SLOTS];

    logic              p3_valid_reg;
    logic              p3_ok_reg;
    logic [SLOT_W-1:0] p3_idx_reg;
    hit_t              p3_hit_reg [WINDOW_SLOTS];

    logic m_valid_reg;
    res_t m_res_reg;

    // Stage handshakes
    logic out_ready, p3_ready, p2_ready, p1_ready;

    // Offset stage signals
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              wr_en;
    slot_t             slot_next;
    logic              p2_ok_next;
    logic [SLOT_W-1:0] p2_idx_next;
    logic              p2_hit_en_next;
    geo_t              p2_geo_next [WINDOW_SLOTS];

    // Compare and select stage signals
    hit_t              p3_hit_next [WINDOW_SLOTS];
    res_t              m_res_next;
    logic [SLOT_W+2:0] idx_ext;

    item_t in_item;

    // A stage may load when it is empty or its word moves on
    assign out_ready = !m_valid_reg  || m_tready;
    assign p3_ready  = !p3_valid_reg || out_ready;
    assign p2_ready  = !p2_valid_reg || p3_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign s_tready  = p1_ready;

    // Unpack the input word
    always_comb begin
        in_item.cmd    = cmd_t'(s_tuser[0]);
        in_item.left   = $signed(s_tdata[10:0]);
        in_item.top    = $signed(s_tdata[21:11]);
        in_item.width  = s_tdata[31:22];
        in_item.height = s_tdata[41:32];
        in_item.color  = s_tdata[49:42];
        in_item.px     = s_tdata[58:50];
        in_item.py     = s_tdata[66:59];
    end

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
            if (!vis_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // A create claims its slot as it leaves the input register, so any query
    // behind it sees the new window and any query ahead of it does not.
    assign wr_en = p1_valid_reg && p2_ready && (p1_item_reg.cmd == CMD_CREATE) && free_found;

    always_comb begin
        slot_next.left   = p1_item_reg.left;
        slot_next.top    = p1_item_reg.top;
        slot_next.width  = p1_item_reg.width;
        slot_next.height = p1_item_reg.height;
        slot_next.color  = p1_item_reg.color;
    end

    // Offset stage: pixel position relative to each window's corner
    always_comb begin
        p2_ok_next     = (p1_item_reg.cmd == CMD_CREATE) && free_found;
        p2_idx_next    = p2_ok_next ? free_idx : '0;
        p2_hit_en_next = (p1_item_reg.cmd == CMD_QUERY)
                         && ({1'b0, p1_item_reg.px} < SCR_W)
                         && ({2'b00, p1_item_reg.py} < SCR_H);
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            p2_geo_next[i].vis    = vis_reg[i];
            p2_geo_next[i].dx     = 12'({3'b000, p1_item_reg.px})
                                    - 12'({slot_reg[i].left[10], slot_reg[i].left});
            p2_geo_next[i].dy     = 12'({4'b0000, p1_item_reg.py})
                                    - 12'({slot_reg[i].top[10], slot_reg[i].top});
            p2_geo_next[i].width  = slot_reg[i].width;
            p2_geo_next[i].height = slot_reg[i].height;
            p2_geo_next[i].color  = slot_reg[i].color;
        end
    end

    // Compare stage: border beats title bar, title bar beats body
    always_comb begin
        logic signed [11:0] wl, wm1, hl, hm1;
        logic               in_cols, in_rows, in_title, border;
        wl       = '0;
        wm1      = '0;
        hl       = '0;
        hm1      = '0;
        in_cols  = 1'b0;
        in_rows  = 1'b0;
        in_title = 1'b0;
        border   = 1'b0;
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            wl       = $signed({2'b00, p2_geo_reg[i].width});
            wm1      = wl - 12'sd1;
            hl       = $signed({2'b00, p2_geo_reg[i].height});
            hm1      = hl - 12'sd1;
            in_cols  = (p2_geo_reg[i].dx >= 12'sd0) && (p2_geo_reg[i].dx < wl);
            in_rows  = (p2_geo_reg[i].dy >= 12'sd0) && (p2_geo_reg[i].dy < hl);
            in_title = (p2_geo_reg[i].dy >= 12'sd0) && (p2_geo_reg[i].dy < TITLE_LIM);
            // A zero size still paints the edge one before the corner.
            border   = (in_cols && ((p2_geo_reg[i].dy == 12'sd0)
                                    || (p2_geo_reg[i].dy == hm1)))
                       || (in_rows && ((p2_geo_reg[i].dx == 12'sd0)
                                       || (p2_geo_reg[i].dx == wm1)));
            p3_hit_next[i].paint = p2_hit_en_reg && p2_geo_reg[i].vis
                                   && (border || (in_cols && (in_title || in_rows)));
            if (border) begin
                p3_hit_next[i].color = BORDER_COLOR;
            end else if (in_title) begin
                p3_hit_next[i].color = TITLE_COLOR;
            end else begin
                p3_hit_next[i].color = p2_geo_reg[i].color;
            end
        end
    end

    // Select stage: the highest painting slot wins
    assign idx_ext = {3'b000, p3_idx_reg};

    always_comb begin
        m_res_next.create_ok     = p3_ok_reg;
        m_res_next.slot_index    = idx_ext[2:0];
        m_res_next.pixel_color   = '0;
        m_res_next.pixel_covered = 1'b0;
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            if (p3_hit_reg[i].paint) begin
                m_res_next.pixel_color   = p3_hit_reg[i].color;
                m_res_next.pixel_covered = 1'b1;
            end
        end
    end

    // Control state: valid bits and slot occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vis_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                vis_reg[free_idx] <= 1'b1;
            end
            if (p1_ready) begin
                p1_valid_reg <= s_tvalid;
            end
            if (p2_ready) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (p3_ready) begin
                p3_valid_reg <= p2_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= p3_valid_reg;
            end
        end
    end

    // Payload registers and window table contents
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[free_idx] <= slot_next;
        end
        if (s_tvalid && p1_ready) begin
            p1_item_reg <= in_item;
        end
        if (p1_valid_reg && p2_ready) begin
            p2_ok_reg     <= p2_ok_next;
            p2_idx_reg    <= p2_idx_next;
            p2_hit_en_reg <= p2_hit_en_next;
            p2_geo_reg    <= p2_geo_next;
        end
        if (p2_valid_reg && p3_ready) begin
            p3_ok_reg  <= p2_ok_reg;
            p3_idx_reg <= p2_idx_reg;
            p3_hit_reg <= p3_hit_next;
        end
        if (p3_valid_reg && out_ready) begin
            m_res_reg <= m_res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_res_reg};

    // A create only ever claims a slot that was free.
    a_claim_free: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !vis_reg[free_idx])
        else $error("create claimed a slot already in use");

    // Slots are never released once taken.
    a_vis_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ((vis_reg & $past(vis_reg)) == $past(vis_reg)))
        else $error("window slot released");

    // A stalled offset stage keeps its word.
    a_p2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p2_valid_reg && !p3_ready) |=> p2_valid_reg)
        else $error("offset stage dropped a stalled word");

    // A create that fails leaves the table as it was.
    a_full_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p2_ready && (p1_item_reg.cmd == CMD_CREATE) && (&vis_reg))
        |=> $stable(vis_reg))
        else $error("table changed on a create into a full table");

endmodule
